/* src/u8bmp_pkg.sv */
package u8bmp_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CodeW = 16;
    localparam int unsigned StatW = 2;

    // byte class bounds
    localparam logic [ByteW-1:0] ASCII_MAX  = 8'h7f;
    localparam logic [ByteW-1:0] LEAD2_MIN  = 8'hc0;
    localparam logic [ByteW-1:0] LEAD3_MIN  = 8'he0;
    localparam logic [ByteW-1:0] LEAD2_MASK = 8'h1f;
    localparam logic [ByteW-1:0] LEAD3_MASK = 8'h0f;
    localparam logic [ByteW-1:0] CONT_MASK  = 8'h3f;

    localparam logic [CodeW-1:0] REPLACE_CP = 16'h003f;

    typedef enum logic [StatW-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_TRUNC    = 2'd2
    } t_status;

    // continuation bytes still owed
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } t_pending;

    typedef struct packed {
        logic [CodeW-1:0] code_point;
        t_status          status;
        logic             stream_end;
    } t_result;

    typedef struct packed {
        logic [ByteW-1:0] byte_in;
        logic             end_of_string;
    } t_item;

    // decoder to top: result strobe and state view
    typedef struct packed {
        logic     produced;
        t_pending pending;
    } t_dec_stat;

endpackage

/* src/u8bmp_if.sv */
interface u8bmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_string;

    modport source (output valid, output byte_in, output end_of_string, input ready);
    modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface u8bmp_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_point;
    logic [1:0]  result_status;
    logic        stream_end;

    modport source (output valid, output code_point, output result_status,
                    output stream_end, input ready);
    modport sink   (input valid, input code_point, input result_status,
                    input stream_end, output ready);
endinterface

/* src/u8bmp_in_stage.sv */
module u8bmp_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    u8bmp_byte_if.sink      i_bus,
    input  logic            i_advance,
    output logic            o_valid,
    output u8bmp_pkg::t_item o_item
);
    import u8bmp_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    logic  w_take;

    assign i_bus.ready = !r_valid || i_advance;
    assign w_take      = i_bus.valid && i_bus.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.byte_in       <= i_bus.byte_in;
            r_item.end_of_string <= i_bus.end_of_string;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

/* src/u8bmp_decode.sv */
module u8bmp_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  u8bmp_pkg::t_item      i_item,
    output u8bmp_pkg::t_result    o_result,
    output u8bmp_pkg::t_dec_stat  o_stat
);
    import u8bmp_pkg::*;

    t_pending         r_pending, n_pending;
    logic [CodeW-1:0] r_partial, n_partial;
    logic             w_produced;
    t_result          w_res;
    logic [ByteW-1:0] w_b;
    logic [5:0]       w_cont;

    assign w_b    = i_item.byte_in;
    assign w_cont = w_b[5:0];

    always_comb begin
        n_pending        = r_pending;
        n_partial        = r_partial;
        w_produced       = 1'b0;
        w_res.code_point = '0;
        w_res.status     = ST_OK;
        w_res.stream_end = i_item.end_of_string;
        case (r_pending)
            PEND_NONE: begin
                if (w_b <= ASCII_MAX) begin
                    w_produced       = 1'b1;
                    w_res.code_point = {8'd0, w_b};
                end else if (w_b >= LEAD3_MIN) begin
                    n_partial = {(w_b[3:0] & LEAD3_MASK[3:0]), 12'd0};
                    n_pending = PEND_TWO;
                end else if (w_b >= LEAD2_MIN) begin
                    n_partial = {5'd0, (w_b[4:0] & LEAD2_MASK[4:0]), 6'd0};
                    n_pending = PEND_ONE;
                end else begin
                    w_produced       = 1'b1;
                    w_res.code_point = REPLACE_CP;
                    w_res.status     = ST_BAD_LEAD;
                end
            end
            PEND_ONE: begin
                w_produced       = 1'b1;
                w_res.code_point = r_partial | {10'd0, (w_cont & CONT_MASK[5:0])};
                n_pending        = PEND_NONE;
                n_partial        = '0;
            end
            default: begin
                // two owed (three cannot arise): middle byte lands at [11:6]
                n_partial = r_partial | {4'd0, (w_cont & CONT_MASK[5:0]), 6'd0};
                n_pending = PEND_ONE;
            end
        endcase

        if (i_item.end_of_string) begin
            if (!w_produced) begin
                w_produced       = 1'b1;
                w_res.code_point = '0;
                w_res.status     = ST_TRUNC;
            end
            n_pending = PEND_NONE;
            n_partial = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= PEND_NONE;
            r_partial <= '0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

    assign o_result        = w_res;
    assign o_stat.produced = w_produced;
    assign o_stat.pending  = r_pending;
endmodule

/* src/u8bmp_out_stage.sv */
module u8bmp_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  u8bmp_pkg::t_result i_result,
    output logic               o_free,
    u8bmp_char_if.source       o_bus
);
    import u8bmp_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_free = !r_valid || o_bus.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_bus.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_bus.valid         = r_valid;
    assign o_bus.code_point    = r_res.code_point;
    assign o_bus.result_status = r_res.status;
    assign o_bus.stream_end    = r_res.stream_end;
endmodule

/* src/utf8_to_bmp_decoder.sv */
// Channel   Dir  Payload                                     Beat on
// i_byte    in   byte_in[7:0], end_of_string                 valid & ready
// o_char    out  code_point[15:0], result_status[1:0],       valid & ready
//                stream_end
//
// One byte per cycle sustained. A byte is registered, decoded against the
// sequence state and, if it yields a character, lands in the output
// register. Reset (i_rst_n low, synchronous) empties both stages and
// clears the sequence state. A stall on o_char backs up only when the
// output register is full and the held byte would produce a result;
// bytes that only feed a pending sequence still drain.
module utf8_to_bmp_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8bmp_byte_if.sink    i_byte,
    u8bmp_char_if.source  o_char
);
    import u8bmp_pkg::*;

    logic      w_in_valid;
    t_item     w_item;
    t_result   w_res;
    t_dec_stat w_stat;
    logic      w_out_free;
    logic      w_advance;
    logic      w_load;

    // held byte moves on unless it has a character to deliver and the
    // output register is still occupied
    assign w_advance = w_in_valid && (!w_stat.produced || w_out_free);
    assign w_load    = w_advance && w_stat.produced;

    u8bmp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bus     (i_byte),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    u8bmp_decode u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (w_item),
        .o_result (w_res),
        .o_stat   (w_stat)
    );

    u8bmp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_res),
        .o_free   (w_out_free),
        .o_bus    (o_char)
    );

    // every final byte closes with exactly one result
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_item.end_of_string) |-> w_stat.produced)
        else $error("final byte produced no result");

    // string end leaves the decoder clean
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_item.end_of_string) |=> (w_stat.pending == PEND_NONE))
        else $error("sequence state survived end of string");

    // truncation result is zero and flagged as the end
    a_trunc_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_res.status == ST_TRUNC) |->
            (w_res.code_point == '0 && w_res.stream_end))
        else $error("malformed truncation result");

    // three pending continuation bytes never arise
    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pending != 2'd3)
        else $error("pending count out of range");
endmodule
